// ----- hdl/array_linked_list_engine_macros.svh -----
// Assertion macros shared by the linked list engine RTL.
// Included by files that carry concurrent assertions; no other dependencies.
`ifndef ARRAY_LINKED_LIST_ENGINE_MACROS_SVH
`define ARRAY_LINKED_LIST_ENGINE_MACROS_SVH

// The condition holds at every clock edge outside reset.
`define ALLE_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) else $error(msg);

// When the trigger holds, the consequence holds on the following clock edge.
`define ALLE_ASSERT_NEXT(lbl, clk, rst_n, trig, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (trig) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/alle_pkg.sv -----
// Shared command codes and types for the linked list engine.
// No dependencies; imported by the top level.
package alle_pkg;

    typedef logic [2:0] t_cmd;

    localparam t_cmd CMD_HEAD_INS = 3'd0;
    localparam t_cmd CMD_TAIL_INS = 3'd1;
    localparam t_cmd CMD_ORD_INS  = 3'd2;
    localparam t_cmd CMD_HEAD_DEL = 3'd3;
    localparam t_cmd CMD_TAIL_DEL = 3'd4;
    localparam t_cmd CMD_SEARCH   = 3'd5;

    localparam int unsigned VALUE_W = 32;
    localparam int unsigned RESULT_W = 8;

endpackage

// ----- hdl/alle_ram.sv -----
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module alle_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- hdl/alle_link_store.sv -----
// Link memory with a fill count that stands in for the reset contents.
// Depends on alle_ram.
module alle_link_store #(
    parameter int unsigned CAPACITY = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_rd_en,
    input  logic [$clog2(CAPACITY)-1:0]         i_rd_addr,
    output logic [$clog2(CAPACITY+1)-1:0]       o_rd_data,
    input  logic                                i_wr_en,
    input  logic [$clog2(CAPACITY)-1:0]         i_wr_addr,
    input  logic [$clog2(CAPACITY+1)-1:0]       i_wr_data
);

    localparam int unsigned AW = $clog2(CAPACITY);
    localparam int unsigned LW = $clog2(CAPACITY+1);

    // Nodes at or above the fill count were never written; their link is index plus one.
    // Nodes are first written in index order, so the count is a clean boundary.
    logic [LW-1:0] r_fill, n_fill;
    logic [AW-1:0] r_rd_addr;
    logic          r_rd_fresh;
    logic [LW-1:0] ram_q;

    alle_ram #(
        .WIDTH (LW),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_wr_en),
        .i_wr_addr (i_wr_addr),
        .i_wr_data (i_wr_data),
        .i_rd_en   (i_rd_en),
        .i_rd_addr (i_rd_addr),
        .o_rd_data (ram_q)
    );

    always_comb begin
        n_fill = r_fill;
        if (i_wr_en && LW'(i_wr_addr) == r_fill) begin
            n_fill = r_fill + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else begin
            r_fill <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_addr  <= i_rd_addr;
            r_rd_fresh <= (LW'(i_rd_addr) >= r_fill);
        end
    end

    assign o_rd_data = r_rd_fresh ? (LW'(r_rd_addr) + 1'b1) : ram_q;

endmodule

// ----- hdl/array_linked_list_engine.sv -----
// Top level of the array backed linked list engine with a free list.
// Depends on alle_pkg, alle_ram, alle_link_store and the assertion macro header.
//
//  Channel   Direction  Word contents (lowest bit first)
//  s_axis    in         tuser: command[2:0]; tdata: operand[31:0]
//  m_axis    out        tdata: ok[0], list_full[1], list_empty[2], zero[7:3]
//
// Unused codes and failed inserts or deletes go straight to the finish state; an
// ordered insert may walk the whole list, one node per read, since each node's
// words come back through the registered read port of the node memories.
// Reset is synchronous and active low; it leaves the list empty and all nodes on
// the free list, with no clearing pass since a fill count supplies the initial links.
// A result waiting in the output register does not block acceptance of the next
// word; only the finish of that next command waits for the register to drain.

`include "array_linked_list_engine_macros.svh"

module array_linked_list_engine
    import alle_pkg::*;
#(
    parameter int unsigned CAPACITY = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_axis_tvalid,
    output logic                o_s_axis_tready,
    input  logic [VALUE_W-1:0]  i_s_axis_tdata,   // operand[31:0]
    input  logic [2:0]          i_s_axis_tuser,   // command[2:0]
    output logic                o_m_axis_tvalid,
    input  logic                i_m_axis_tready,
    output logic [RESULT_W-1:0] o_m_axis_tdata    // ok, list_full, list_empty, zero fill
);

    localparam int unsigned AW = $clog2(CAPACITY);
    localparam int unsigned LW = $clog2(CAPACITY+1);
    localparam logic [LW-1:0] END_MARK = LW'(CAPACITY);

    // Sequencer states.
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_POP  = 3'd1;   // link of the free head is on the read port
    localparam logic [2:0] ST_WALK = 3'd2;   // node r_cur is on the read port
    localparam logic [2:0] ST_WR1  = 3'd3;
    localparam logic [2:0] ST_WR2  = 3'd4;
    localparam logic [2:0] ST_HDEL = 3'd5;   // link of the head is on the read port
    localparam logic [2:0] ST_FIN  = 3'd6;

    logic [2:0]          r_state, n_state;
    logic [LW-1:0]       r_head, n_head;
    logic [LW-1:0]       r_free, n_free;
    logic                r_out_valid, n_out_valid;
    logic [RESULT_W-1:0] r_out_data, n_out_data;

    t_cmd                r_cmd, n_cmd;
    logic [VALUE_W-1:0]  r_val, n_val;
    logic [LW-1:0]       r_cur, n_cur;
    logic [LW-1:0]       r_prev, n_prev;
    logic [LW-1:0]       r_node, n_node;
    logic                r_ok, n_ok;

    // Shared read port of both memories, and their write ports.
    logic                rd_en;
    logic [AW-1:0]       rd_addr;
    logic [LW-1:0]       lnk_q;
    logic [VALUE_W-1:0]  val_q;
    logic                lk_we;
    logic [AW-1:0]       lk_waddr;
    logic [LW-1:0]       lk_wdata;
    logic                val_we;
    logic [AW-1:0]       val_waddr;

    logic full, empty, cur_end, advance, out_load, accept;

    assign full    = (r_free >= END_MARK);
    assign empty   = (r_head >= END_MARK);
    assign cur_end = (r_cur >= END_MARK);
    assign accept  = i_s_axis_tvalid && o_s_axis_tready;
    assign out_load = (r_state == ST_FIN) && (!r_out_valid || i_m_axis_tready);

    alle_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (CAPACITY)
    ) u_values (
        .i_clk     (i_clk),
        .i_wr_en   (val_we),
        .i_wr_addr (val_waddr),
        .i_wr_data (r_val),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (val_q)
    );

    alle_link_store #(
        .CAPACITY (CAPACITY)
    ) u_links (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (lnk_q),
        .i_wr_en   (lk_we),
        .i_wr_addr (lk_waddr),
        .i_wr_data (lk_wdata)
    );

    // Whether the walk moves on from the node whose words just came back.
    always_comb begin
        case (r_cmd)
            CMD_TAIL_INS: advance = !cur_end;
            CMD_ORD_INS:  advance = !cur_end && ($signed(val_q) < $signed(r_val));
            CMD_TAIL_DEL: advance = (lnk_q < END_MARK);
            CMD_SEARCH:   advance = !cur_end && (val_q != r_val);
            default:      advance = 1'b0;
        endcase
    end

    // The sequencer never reads and writes the memories in the same cycle, so
    // no forwarding path is needed between the write and read ports.
    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_free      = r_free;
        n_cmd       = r_cmd;
        n_val       = r_val;
        n_cur       = r_cur;
        n_prev      = r_prev;
        n_node      = r_node;
        n_ok        = r_ok;
        n_out_data  = r_out_data;
        n_out_valid = r_out_valid && !i_m_axis_tready;
        rd_en       = 1'b0;
        rd_addr     = r_cur[AW-1:0];
        lk_we       = 1'b0;
        lk_waddr    = r_node[AW-1:0];
        lk_wdata    = r_cur;
        val_we      = 1'b0;
        val_waddr   = r_node[AW-1:0];

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_cmd  = i_s_axis_tuser;
                    n_val  = i_s_axis_tdata;
                    n_ok   = 1'b0;
                    n_cur  = r_head;
                    n_prev = END_MARK;
                    n_state = ST_FIN;
                    case (i_s_axis_tuser)
                        CMD_HEAD_INS, CMD_TAIL_INS, CMD_ORD_INS: begin
                            if (!full) begin
                                rd_en   = 1'b1;
                                rd_addr = r_free[AW-1:0];
                                n_state = ST_POP;
                            end
                        end
                        CMD_HEAD_DEL: begin
                            if (!empty) begin
                                rd_en   = 1'b1;
                                rd_addr = r_head[AW-1:0];
                                n_state = ST_HDEL;
                            end
                        end
                        CMD_TAIL_DEL, CMD_SEARCH: begin
                            if (!empty) begin
                                rd_en   = 1'b1;
                                rd_addr = r_head[AW-1:0];
                                n_state = ST_WALK;
                            end
                        end
                        default: begin
                            n_state = ST_FIN;
                        end
                    endcase
                end
            end
            ST_POP: begin
                n_node = r_free;
                n_free = lnk_q;
                if (r_cmd == CMD_HEAD_INS) begin
                    val_we    = 1'b1;
                    val_waddr = r_free[AW-1:0];
                    lk_we     = 1'b1;
                    lk_waddr  = r_free[AW-1:0];
                    lk_wdata  = r_head;
                    n_head    = r_free;
                    n_ok      = 1'b1;
                    n_state   = ST_FIN;
                end else begin
                    n_cur   = r_head;
                    n_prev  = END_MARK;
                    rd_en   = !empty;
                    rd_addr = r_head[AW-1:0];
                    n_state = ST_WALK;
                end
            end
            ST_WALK: begin
                if (advance) begin
                    n_prev  = r_cur;
                    n_cur   = lnk_q;
                    rd_en   = (lnk_q < END_MARK);
                    rd_addr = lnk_q[AW-1:0];
                end else if (r_cmd == CMD_SEARCH) begin
                    n_ok    = !cur_end;
                    n_state = ST_FIN;
                end else begin
                    n_state = ST_WR1;
                end
            end
            ST_WR1: begin
                lk_we = 1'b1;
                if (r_cmd == CMD_TAIL_DEL) begin
                    lk_waddr = r_cur[AW-1:0];
                    lk_wdata = r_free;
                    n_free   = r_cur;
                end else begin
                    val_we = 1'b1;
                end
                n_state = ST_WR2;
            end
            ST_WR2: begin
                lk_waddr = r_prev[AW-1:0];
                lk_wdata = (r_cmd == CMD_TAIL_DEL) ? END_MARK : r_node;
                if (r_prev < END_MARK) begin
                    lk_we = 1'b1;
                end else begin
                    n_head = lk_wdata;
                end
                n_ok    = 1'b1;
                n_state = ST_FIN;
            end
            ST_HDEL: begin
                n_head   = lnk_q;
                lk_we    = 1'b1;
                lk_waddr = r_head[AW-1:0];
                lk_wdata = r_free;
                n_free   = r_head;
                n_ok     = 1'b1;
                n_state  = ST_FIN;
            end
            ST_FIN: begin
                if (out_load) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {{(RESULT_W-3){1'b0}}, empty, full, r_ok};
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_head      <= END_MARK;
            r_free      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_free      <= n_free;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_val      <= n_val;
        r_cur      <= n_cur;
        r_prev     <= n_prev;
        r_node     <= n_node;
        r_ok       <= n_ok;
        r_out_data <= n_out_data;
    end

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    // A node never heads both the list and the free list. The one exception is
    // the cycle in which a tail delete has freed the only node and the head
    // pointer is cleared on the next edge.
    `ALLE_ASSERT_ALWAYS(a_heads_disjoint, i_clk, i_rst_n,
        !(r_state != ST_WR2 && r_head < END_MARK && r_head == r_free),
        "list head and free head coincide")

    // A tail delete only walks real nodes.
    `ALLE_ASSERT_ALWAYS(a_tdel_walk_in_list, i_clk, i_rst_n,
        !(r_state == ST_WALK && r_cmd == CMD_TAIL_DEL && cur_end),
        "tail delete walked past the end")

    // A successful insert never reports an empty list.
    `ALLE_ASSERT_NEXT(a_insert_not_empty, i_clk, i_rst_n,
        out_load && r_ok && (r_cmd == CMD_HEAD_INS || r_cmd == CMD_TAIL_INS || r_cmd == CMD_ORD_INS),
        !o_m_axis_tdata[2], "insert reported an empty list")

endmodule

// ----- tb/sv/array_linked_list_engine_tb.sv -----
// Self-checking testbench for array_linked_list_engine: a directed set of list commands,
// then about 1650 random commands in fill, drain and mixed phases, with random idling.
// Depends on alle_pkg and the engine RTL only.
module array_linked_list_engine_tb;
    import alle_pkg::*;

    localparam int unsigned CAP = 16;
    localparam int unsigned IDX_W = $clog2(CAP + 1);
    localparam int unsigned SLOT_W = $clog2(CAP);
    localparam logic [IDX_W-1:0] END_IDX = IDX_W'(CAP);

    // Command codes the engine does not use; they must leave the list alone.
    localparam t_cmd CMD_SPARE_6 = 3'd6;
    localparam t_cmd CMD_SPARE_7 = 3'd7;

    localparam int RANDOM_ITEMS = 1650;
    localparam int STUCK_LIMIT = 3000;
    localparam int HOLD_CYCLES = 300;
    localparam int TAIL_CYCLES = 2 * (CAP + 5);
    localparam int REPORT_CAP = 100;

    typedef struct {
        t_cmd        cmd;
        logic [31:0] operand;
    } t_list_cmd;

    // Packed so that ok sits in bit 0, as on the result word.
    typedef struct packed {
        logic list_empty;
        logic list_full;
        logic ok;
    } t_list_status;

    typedef enum logic [1:0] {FILL_PHASE, DRAIN_PHASE, MIX_PHASE} t_gen_phase;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    logic                s_valid = 1'b0;
    logic [2:0]          s_cmd = 3'd0;
    logic [VALUE_W-1:0]  s_operand = '0;
    logic                s_ready;
    logic                m_valid;
    logic                m_tready = 1'b0;
    logic [RESULT_W-1:0] m_data;

    t_list_cmd    pending_cmds [$];
    t_list_status expected_status [$];
    logic [31:0]  recent_vals [$];

    // Shadow copy of the node store used for prediction.
    logic signed [31:0] node_val [CAP];
    logic [IDX_W-1:0]   node_nxt [CAP];
    logic [IDX_W-1:0]   list_head;
    logic [IDX_W-1:0]   free_head;

    int failures = 0;
    int results_seen = 0;
    int stuck_cycles = 0;
    int burst_left = 0;
    int gap_left = 0;
    int hold_left = 0;
    int holds_taken = 0;
    int stall_mode = 0;
    int stall_mode_left = 0;

    t_cmd insert_cmds [3];
    t_cmd delete_cmds [2];
    t_cmd spare_cmds [2];
    t_cmd all_cmds [6];

    array_linked_list_engine #(.CAPACITY(CAP)) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_operand),  // operand[31:0]
        .i_s_axis_tuser  (s_cmd),      // command[2:0]
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_data)      // ok, list_full, list_empty, zero fill
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Any link at or above the capacity reads as the end marker.
    function automatic logic [IDX_W-1:0] next_of(input logic [IDX_W-1:0] idx);
        if (idx < END_IDX && node_nxt[idx[SLOT_W-1:0]] < END_IDX) begin
            return node_nxt[idx[SLOT_W-1:0]];
        end
        return END_IDX;
    endfunction

    // Runs one command on the shadow list and queues the status word it must produce.
    task automatic apply_list_command(input t_cmd cmd, input logic signed [31:0] operand);
        t_list_status     st;
        logic [IDX_W-1:0] prev;
        logic [IDX_W-1:0] cur;
        logic [IDX_W-1:0] n;
        int               steps;
        logic             was_full;
        logic             was_empty;
        st.ok = 1'b0;
        was_full = (free_head >= END_IDX);
        was_empty = (list_head >= END_IDX);
        steps = 0;
        case (cmd)
            CMD_HEAD_INS: begin
                if (!was_full) begin
                    n = free_head;
                    free_head = next_of(n);
                    node_val[n[SLOT_W-1:0]] = operand;
                    node_nxt[n[SLOT_W-1:0]] = was_empty ? END_IDX : list_head;
                    list_head = n;
                    st.ok = 1'b1;
                end
            end
            CMD_TAIL_INS, CMD_ORD_INS: begin
                if (!was_full) begin
                    n = free_head;
                    free_head = next_of(n);
                    prev = END_IDX;
                    cur = was_empty ? END_IDX : list_head;
                    // Tail insert walks to the end; ordered insert stops at the
                    // first node whose value is not below the operand (signed).
                    while (cur < END_IDX && steps < CAP &&
                           (cmd == CMD_TAIL_INS || node_val[cur[SLOT_W-1:0]] < operand)) begin
                        prev = cur;
                        cur = next_of(cur);
                        steps++;
                    end
                    node_val[n[SLOT_W-1:0]] = operand;
                    node_nxt[n[SLOT_W-1:0]] = cur;
                    if (prev < END_IDX) begin
                        node_nxt[prev[SLOT_W-1:0]] = n;
                    end else begin
                        list_head = n;
                    end
                    st.ok = 1'b1;
                end
            end
            CMD_HEAD_DEL: begin
                if (!was_empty) begin
                    n = list_head;
                    list_head = next_of(n);
                    node_nxt[n[SLOT_W-1:0]] = was_full ? END_IDX : free_head;
                    free_head = n;
                    st.ok = 1'b1;
                end
            end
            CMD_TAIL_DEL: begin
                if (!was_empty) begin
                    prev = END_IDX;
                    cur = list_head;
                    while (next_of(cur) < END_IDX && steps < CAP) begin
                        prev = cur;
                        cur = next_of(cur);
                        steps++;
                    end
                    if (prev < END_IDX) begin
                        node_nxt[prev[SLOT_W-1:0]] = END_IDX;
                    end else begin
                        list_head = END_IDX;
                    end
                    node_nxt[cur[SLOT_W-1:0]] = was_full ? END_IDX : free_head;
                    free_head = cur;
                    st.ok = 1'b1;
                end
            end
            CMD_SEARCH: begin
                cur = was_empty ? END_IDX : list_head;
                while (!st.ok && cur < END_IDX && steps < CAP) begin
                    if (node_val[cur[SLOT_W-1:0]] == operand) begin
                        st.ok = 1'b1;
                    end
                    cur = next_of(cur);
                    steps++;
                end
            end
            default: begin
            end
        endcase
        st.list_full = (free_head >= END_IDX);
        st.list_empty = (list_head >= END_IDX);
        expected_status.push_back(st);
    endtask

    // Operands lean on a few small values and on recently inserted ones so that
    // searches hit and ordered inserts meet equal values.
    function automatic logic [31:0] pick_operand();
        logic [31:0] v;
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 35) begin
            v = $urandom_range(0, 15) - 8;
        end else if (roll < 55 && recent_vals.size() != 0) begin
            v = recent_vals[$urandom_range(0, recent_vals.size() - 1)];
        end else if (roll < 65) begin
            v = ($urandom_range(0, 1) != 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
        end else begin
            v = $urandom();
        end
        return v;
    endfunction

    task automatic push_cmd(input t_cmd cmd, input logic [31:0] operand);
        t_list_cmd item;
        item.cmd = cmd;
        item.operand = operand;
        pending_cmds.push_back(item);
        if (cmd == CMD_HEAD_INS || cmd == CMD_TAIL_INS || cmd == CMD_ORD_INS) begin
            recent_vals.push_back(operand);
            if (recent_vals.size() > 24) begin
                void'(recent_vals.pop_front());
            end
        end
    endtask

    // Sender: offers words in bursts separated by random gaps, and predicts each
    // command at the edge where it is accepted.
    always @(posedge i_clk) begin
        t_list_cmd next_item;
        if (!i_rst_n) begin
            s_valid <= 1'b0;
            burst_left <= 0;
            gap_left <= 0;
        end else begin
            if (s_valid && s_ready) begin
                apply_list_command(t_cmd'(s_cmd), s_operand);
            end
            if (!s_valid || s_ready) begin
                if (gap_left != 0) begin
                    gap_left <= gap_left - 1;
                    s_valid <= 1'b0;
                end else if (pending_cmds.size() != 0) begin
                    next_item = pending_cmds.pop_front();
                    s_valid <= 1'b1;
                    s_cmd <= next_item.cmd;
                    s_operand <= next_item.operand;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 30);
                        gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 25);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-offs, so the engine backs up and stalls its input.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
            holds_taken <= 0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (holds_taken < 2 && results_seen >= (holds_taken + 1) * 500) begin
            hold_left <= HOLD_CYCLES;
            holds_taken <= holds_taken + 1;
        end
    end

    // Receiver: checks each result word against the oldest prediction and
    // stalls on a pattern that switches between full rate, half rate and sparse.
    always @(posedge i_clk) begin
        t_list_status want;
        logic         rdy;
        if (!i_rst_n) begin
            m_tready <= 1'b0;
            stall_mode <= 0;
            stall_mode_left <= 0;
        end else begin
            if (m_valid && m_tready) begin
                results_seen <= results_seen + 1;
                if (expected_status.size() == 0) begin
                    failures++;
                    if (failures <= REPORT_CAP) begin
                        $error("result word 0x%0h arrived with nothing predicted", m_data);
                    end
                end else begin
                    want = expected_status.pop_front();
                    if (m_data[0] !== want.ok) begin
                        failures++;
                        if (failures <= REPORT_CAP) begin
                            $error("ok: expected %0b, got %0b", want.ok, m_data[0]);
                        end
                    end
                    if (m_data[1] !== want.list_full) begin
                        failures++;
                        if (failures <= REPORT_CAP) begin
                            $error("list_full: expected %0b, got %0b",
                                   want.list_full, m_data[1]);
                        end
                    end
                    if (m_data[2] !== want.list_empty) begin
                        failures++;
                        if (failures <= REPORT_CAP) begin
                            $error("list_empty: expected %0b, got %0b",
                                   want.list_empty, m_data[2]);
                        end
                    end
                end
            end
            if (stall_mode_left == 0) begin
                stall_mode <= $urandom_range(0, 2);
                stall_mode_left <= $urandom_range(1, 64);
            end else begin
                stall_mode_left <= stall_mode_left - 1;
            end
            case (stall_mode)
                0: rdy = 1'b1;
                1: rdy = ($urandom_range(0, 1) != 0);
                default: rdy = ($urandom_range(0, 5) == 0);
            endcase
            m_tready <= rdy && (hold_left == 0);
        end
    end

    // Watchdog: cycles in which no word moves on either side.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_valid && s_ready) || (m_valid && m_tready)) begin
            stuck_cycles <= 0;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    initial begin
        t_gen_phase  phase;
        int          random_left;
        int          run_len;
        int unsigned roll;
        t_cmd        cmd;

        insert_cmds = '{CMD_HEAD_INS, CMD_TAIL_INS, CMD_ORD_INS};
        delete_cmds = '{CMD_HEAD_DEL, CMD_TAIL_DEL};
        spare_cmds = '{CMD_SPARE_6, CMD_SPARE_7};
        all_cmds = '{CMD_HEAD_INS, CMD_TAIL_INS, CMD_ORD_INS,
                     CMD_HEAD_DEL, CMD_TAIL_DEL, CMD_SEARCH};

        // Shadow list after reset: empty, every node on the free chain in order.
        for (int i = 0; i < CAP; i++) begin
            node_val[i] = '0;
            node_nxt[i] = IDX_W'(i + 1);
        end
        list_head = END_IDX;
        free_head = '0;

        // Directed part: everything on an empty list, the unused codes, the
        // extreme operands, ordered inserts meeting equal values, searches
        // that hit and miss, and both deletes.
        push_cmd(CMD_SEARCH,   32'h0000_0000);
        push_cmd(CMD_HEAD_DEL, 32'hFFFF_FFFF);
        push_cmd(CMD_TAIL_DEL, 32'h0000_0000);
        push_cmd(CMD_SPARE_6,  32'h8000_0000);
        push_cmd(CMD_SPARE_7,  32'h7FFF_FFFF);
        push_cmd(CMD_HEAD_INS, 32'h7FFF_FFFF);
        push_cmd(CMD_HEAD_INS, 32'h8000_0000);
        push_cmd(CMD_TAIL_INS, 32'h0000_0000);
        push_cmd(CMD_ORD_INS,  32'hFFFF_FFFF);
        push_cmd(CMD_ORD_INS,  32'h7FFF_FFFF);
        push_cmd(CMD_ORD_INS,  32'h8000_0000);
        push_cmd(CMD_ORD_INS,  32'h0000_0005);
        push_cmd(CMD_SEARCH,   32'h8000_0000);
        push_cmd(CMD_SEARCH,   32'h7FFF_FFFF);
        push_cmd(CMD_SEARCH,   32'h0000_3039);
        push_cmd(CMD_SPARE_7,  32'h0000_0000);
        push_cmd(CMD_TAIL_DEL, 32'h0000_0000);
        push_cmd(CMD_HEAD_DEL, 32'h0000_0000);
        push_cmd(CMD_SEARCH,   32'h0000_0000);
        push_cmd(CMD_SPARE_6,  32'hFFFF_FFFF);

        // Random part: fill phases drive the list to full and beyond, drain
        // phases empty it and keep deleting, mixed phases wander in between.
        random_left = RANDOM_ITEMS;
        while (random_left > 0) begin
            phase = t_gen_phase'($urandom_range(0, 2));
            run_len = $urandom_range(8, 40);
            while (run_len > 0 && random_left > 0) begin
                roll = $urandom_range(0, 99);
                case (phase)
                    FILL_PHASE: begin
                        if (roll < 75) cmd = insert_cmds[$urandom_range(0, 2)];
                        else if (roll < 90) cmd = CMD_SEARCH;
                        else if (roll < 97) cmd = delete_cmds[$urandom_range(0, 1)];
                        else cmd = spare_cmds[$urandom_range(0, 1)];
                    end
                    DRAIN_PHASE: begin
                        if (roll < 70) cmd = delete_cmds[$urandom_range(0, 1)];
                        else if (roll < 85) cmd = CMD_SEARCH;
                        else if (roll < 97) cmd = insert_cmds[$urandom_range(0, 2)];
                        else cmd = spare_cmds[$urandom_range(0, 1)];
                    end
                    default: begin
                        if (roll < 95) cmd = all_cmds[$urandom_range(0, 5)];
                        else cmd = spare_cmds[$urandom_range(0, 1)];
                    end
                endcase
                push_cmd(cmd, pick_operand());
                run_len--;
                random_left--;
            end
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Sample on the falling edge so the clocked processes have settled.
        do begin
            @(negedge i_clk);
        end while (!(pending_cmds.size() == 0 && !s_valid && expected_status.size() == 0)
                   && stuck_cycles < STUCK_LIMIT);

        if (stuck_cycles >= STUCK_LIMIT) begin
            $display("array_linked_list_engine_tb failed");
            $finish;
        end else begin
            // Let any stray extra result show up before the verdict.
            repeat (TAIL_CYCLES) @(negedge i_clk);
            if (failures == 0 && expected_status.size() == 0) begin
                $display("array_linked_list_engine_tb passed");
            end else begin
                $display("array_linked_list_engine_tb failed");
            end
            $finish;
        end
    end

endmodule
